>>> hdl/aapr_pkg.sv
// Package: constants and types for the axis-angle point rotation unit.
`timescale 1ns / 1ps
package aapr_pkg;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [16:0] RAD_PER_STEP = 17'd102944;

  localparam int K42 = 36;
  localparam int K20 = 35;
  localparam int K6  = 33;
  localparam int K56 = 36;
  localparam int K30 = 35;
  localparam int K12 = 34;
  localparam logic [30:0] M42 = 31'(((64'd1 << K42) + 64'd41) / 64'd42);
  localparam logic [30:0] M20 = 31'(((64'd1 << K20) + 64'd19) / 64'd20);
  localparam logic [30:0] M6  = 31'(((64'd1 << K6) + 64'd5) / 64'd6);
  localparam logic [30:0] M56 = 31'(((64'd1 << K56) + 64'd55) / 64'd56);
  localparam logic [30:0] M30 = 31'(((64'd1 << K30) + 64'd29) / 64'd30);
  localparam logic [30:0] M12 = 31'(((64'd1 << K12) + 64'd11) / 64'd12);

  localparam int NCARRY = 12;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [1:0]         quad;
    logic               swap;
  } carry_t;

endpackage

>>> hdl/axis_angle_point_rotation_unit.sv
// Top level: pipelined axis-angle (Rodrigues) rotation of a 3D point.
`timescale 1ns / 1ps
// One item enters per clock; busy is never raised. The result appears on the
// rotated ports with done high once the item has passed through the
// sine/cosine polynomial chain, the matrix build and the dot product.
// The receiver cannot stall, so done must be taken when it is high.
module axis_angle_point_rotation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic [15:0]        turn_angle,
  output logic               done,
  output logic signed [15:0] rotated_x,
  output logic signed [15:0] rotated_y,
  output logic signed [15:0] rotated_z,
  output logic               clipped
);
  import aapr_pkg::*;

  localparam int NST = 14;

  logic [NST-1:0] vld;
  carry_t cr [NCARRY];

  logic        take;
  logic [13:0] r_in;
  logic        swap_in;
  logic [13:0] a_in;

  logic [29:0] x1;
  logic [29:0] x2s;
  logic [59:0] xsq;
  logic [29:0] xd2;
  logic [29:0] x3, x4, x5, x6, x7;
  logic [29:0] q3, q4, q5, q6, q7;
  logic [61:0] ps3, pc3, ps5, pc5, ps7, pc7;
  logic [60:0] ms4, mc4, ms6, mc6, ms8, mc8;
  logic [30:0] ts4, tc4, ts6, tc6, ts8, tc8;
  logic [29:0] s30;
  logic [30:0] c30;
  logic [15:0] s0r, c0r, s0, c0;
  logic signed [15:0] sn9, cs9;

  logic signed [16:0] omc10;
  logic signed [15:0] cs10;
  logic signed [31:0] axx, ayy, azz, axy, axz, ayz, sax, say, saz;
  logic signed [49:0] o00, o11, o22, o01, o02, o12;
  logic signed [15:0] cs11;
  logic signed [31:0] sax11, say11, saz11;
  logic signed [35:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [49:0] cq, e00, e11, e22, e01, e10, e02, e20, e12, e21;
  logic signed [53:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
  logic signed [53:0] accx, accy, accz;
  logic signed [25:0] rx, ry, rz;
  logic               clx, cly, clz;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], take};
    end
  end

  assign r_in    = turn_angle[13:0];
  assign swap_in = r_in > 14'd8192;
  assign a_in    = swap_in ? 14'(15'd16384 - {1'b0, r_in}) : r_in;

  always_ff @(posedge clk) begin
    cr[0] <= '{px: point_x, py: point_y, pz: point_z, ax: axis_x, ay: axis_y,
               az: axis_z, quad: turn_angle[15:14], swap: swap_in};
    for (int i = 1; i < NCARRY; i++) begin
      cr[i] <= cr[i-1];
    end
  end

  // Sine and cosine polynomial chain.
  assign ts4 = Q30_ONE - 31'(ps3 >> K42);
  assign tc4 = Q30_ONE - 31'(pc3 >> K56);
  assign ts6 = Q30_ONE - 31'(ps5 >> K20);
  assign tc6 = Q30_ONE - 31'(pc5 >> K30);
  assign ts8 = Q30_ONE - 31'(ps7 >> K6);
  assign tc8 = Q30_ONE - 31'(pc7 >> K12);
  assign x2s = xsq[59:30];

  always_ff @(posedge clk) begin
    x1  <= 30'(a_in) * 30'(RAD_PER_STEP);
    xsq <= 60'(x1) * 60'(x1);
    xd2 <= x1;
    x3  <= xd2;
    q3  <= x2s;
    ps3 <= 62'(x2s) * 62'(M42);
    pc3 <= 62'(x2s) * 62'(M56);
    x4  <= x3;
    q4  <= q3;
    ms4 <= 61'(q3) * 61'(ts4);
    mc4 <= 61'(q3) * 61'(tc4);
    x5  <= x4;
    q5  <= q4;
    ps5 <= 62'(ms4[60:30]) * 62'(M20);
    pc5 <= 62'(mc4[60:30]) * 62'(M30);
    x6  <= x5;
    q6  <= q5;
    ms6 <= 61'(q5) * 61'(ts6);
    mc6 <= 61'(q5) * 61'(tc6);
    x7  <= x6;
    q7  <= q6;
    ps7 <= 62'(ms6[60:30]) * 62'(M6);
    pc7 <= 62'(mc6[60:30]) * 62'(M12);
    ms8 <= 61'(x7) * 61'(ts8);
    mc8 <= 61'(q7) * 61'(tc8);
  end

  assign s30 = ms8[59:30];
  assign c30 = Q30_ONE - 31'(mc8[60:31]);
  assign s0r = 16'((31'(s30) + 31'd32768) >> 16);
  assign c0r = 16'((c30 + 31'd32768) >> 16);
  assign s0  = cr[7].swap ? c0r : s0r;
  assign c0  = cr[7].swap ? s0r : c0r;

  always_ff @(posedge clk) begin
    case (cr[7].quad)
      2'd0: begin
        sn9 <= $signed(s0);
        cs9 <= $signed(c0);
      end
      2'd1: begin
        sn9 <= $signed(c0);
        cs9 <= -$signed(s0);
      end
      2'd2: begin
        sn9 <= -$signed(s0);
        cs9 <= -$signed(c0);
      end
      default: begin
        sn9 <= -$signed(c0);
        cs9 <= $signed(s0);
      end
    endcase
  end

  // Matrix terms.
  always_ff @(posedge clk) begin
    omc10 <= 17'sd16384 - 17'(cs9);
    cs10  <= cs9;
    axx   <= cr[8].ax * cr[8].ax;
    ayy   <= cr[8].ay * cr[8].ay;
    azz   <= cr[8].az * cr[8].az;
    axy   <= cr[8].ax * cr[8].ay;
    axz   <= cr[8].ax * cr[8].az;
    ayz   <= cr[8].ay * cr[8].az;
    sax   <= sn9 * cr[8].ax;
    say   <= sn9 * cr[8].ay;
    saz   <= sn9 * cr[8].az;
  end

  always_ff @(posedge clk) begin
    o00   <= 50'(omc10) * 50'(axx);
    o11   <= 50'(omc10) * 50'(ayy);
    o22   <= 50'(omc10) * 50'(azz);
    o01   <= 50'(omc10) * 50'(axy);
    o02   <= 50'(omc10) * 50'(axz);
    o12   <= 50'(omc10) * 50'(ayz);
    cs11  <= cs10;
    sax11 <= sax;
    say11 <= say;
    saz11 <= saz;
  end

  assign cq  = 50'(cs11) <<< 28;
  assign e00 = cq + o00 + 50'sd8192;
  assign e11 = cq + o11 + 50'sd8192;
  assign e22 = cq + o22 + 50'sd8192;
  assign e01 = o01 - (50'(saz11) <<< 14) + 50'sd8192;
  assign e10 = o01 + (50'(saz11) <<< 14) + 50'sd8192;
  assign e02 = o02 + (50'(say11) <<< 14) + 50'sd8192;
  assign e20 = o02 - (50'(say11) <<< 14) + 50'sd8192;
  assign e12 = o12 - (50'(sax11) <<< 14) + 50'sd8192;
  assign e21 = o12 + (50'(sax11) <<< 14) + 50'sd8192;

  always_ff @(posedge clk) begin
    m00 <= e00[49:14];
    m11 <= e11[49:14];
    m22 <= e22[49:14];
    m01 <= e01[49:14];
    m10 <= e10[49:14];
    m02 <= e02[49:14];
    m20 <= e20[49:14];
    m12 <= e12[49:14];
    m21 <= e21[49:14];
  end

  // Matrix times point.
  always_ff @(posedge clk) begin
    p00 <= 54'(m00) * 54'(cr[11].px);
    p01 <= 54'(m01) * 54'(cr[11].py);
    p02 <= 54'(m02) * 54'(cr[11].pz);
    p10 <= 54'(m10) * 54'(cr[11].px);
    p11 <= 54'(m11) * 54'(cr[11].py);
    p12 <= 54'(m12) * 54'(cr[11].pz);
    p20 <= 54'(m20) * 54'(cr[11].px);
    p21 <= 54'(m21) * 54'(cr[11].py);
    p22 <= 54'(m22) * 54'(cr[11].pz);
  end

  assign accx = p00 + p01 + p02 + 54'sd134217728;
  assign accy = p10 + p11 + p12 + 54'sd134217728;
  assign accz = p20 + p21 + p22 + 54'sd134217728;
  assign rx   = accx[53:28];
  assign ry   = accy[53:28];
  assign rz   = accz[53:28];
  assign clx  = (rx > 26'sd32767) || (rx < -26'sd32768);
  assign cly  = (ry > 26'sd32767) || (ry < -26'sd32768);
  assign clz  = (rz > 26'sd32767) || (rz < -26'sd32768);

  always_ff @(posedge clk) begin
    rotated_x <= clx ? (rx[25] ? -16'sd32768 : 16'sd32767) : rx[15:0];
    rotated_y <= cly ? (ry[25] ? -16'sd32768 : 16'sd32767) : ry[15:0];
    rotated_z <= clz ? (rz[25] ? -16'sd32768 : 16'sd32767) : rz[15:0];
    clipped   <= clx || cly || clz;
  end

  assign done = vld[NST-1];

endmodule

>>> tb/sv/tb_axis_angle_point_rotation_unit.sv
// Testbench: axis-angle point rotation unit checked against a bit-exact predictor.
`timescale 1ns / 1ps
module tb_axis_angle_point_rotation_unit;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               clip;
  } rotated_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic [15:0] turn_angle = '0;
  logic done;
  logic signed [15:0] rotated_x, rotated_y, rotated_z;
  logic clipped;

  rotated_t pending_rotations[$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  int clipped_seen = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int LATENCY = 14;

  axis_angle_point_rotation_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic void octant(input longint a, output longint s, output longint c);
    longint x, x2, t, one;
    one = 64'd1 << 30;
    x = a * 102944;
    x2 = (x * x) >> 30;
    t = one - x2 / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    t = one - x2 / 56;
    t = one - ((x2 * t) >> 30) / 30;
    t = one - ((x2 * t) >> 30) / 12;
    c = one - ((x2 * t) >> 30) / 2;
  endfunction

  function automatic longint sat_component(longint m0, m1, m2, p0, p1, p2, ref bit clip);
    longint r;
    r = fshift(m0 * p0 + m1 * p1 + m2 * p2 + (64'sd1 <<< 27), 28);
    if (r > 32767) begin clip = 1; r = 32767; end
    if (r < -32768) begin clip = 1; r = -32768; end
    return r;
  endfunction

  function automatic longint q28(longint v);
    return fshift(v + 8192, 14);
  endfunction

  function automatic rotated_t rotate_point(logic signed [15:0] px, py, pz, ax, ay, az,
                                            logic [15:0] ang);
    rotated_t res;
    longint s30, c30, s0, c0, sn, cs, omc, cq, sq, r;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    bit clip;
    clip = 0;
    r = ang[13:0];
    if (r <= 8192) octant(r, s30, c30);
    else octant(16384 - r, c30, s30);
    s0 = (s30 + 32768) >> 16;
    c0 = (c30 + 32768) >> 16;
    case (ang[15:14])
      2'd0: begin sn = s0; cs = c0; end
      2'd1: begin sn = c0; cs = -s0; end
      2'd2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
    omc = 16384 - cs;
    cq = cs * (64'sd1 <<< 28);
    sq = sn * 16384;
    m00 = q28(cq + omc * ax * ax);
    m11 = q28(cq + omc * ay * ay);
    m22 = q28(cq + omc * az * az);
    m01 = q28(omc * ax * ay - az * sq);
    m10 = q28(omc * ax * ay + az * sq);
    m02 = q28(omc * ax * az + ay * sq);
    m20 = q28(omc * ax * az - ay * sq);
    m12 = q28(omc * ay * az - ax * sq);
    m21 = q28(omc * ay * az + ax * sq);
    res.x = 16'(sat_component(m00, m01, m02, px, py, pz, clip));
    res.y = 16'(sat_component(m10, m11, m12, px, py, pz, clip));
    res.z = 16'(sat_component(m20, m21, m22, px, py, pz, clip));
    res.clip = clip;
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_item(logic signed [15:0] px, py, pz, ax, ay, az, logic [15:0] ang,
                           int gap);
    repeat (gap) @(posedge clk) start <= 1'b0;
    @(posedge clk);
    while (busy) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    point_x <= px; point_y <= py; point_z <= pz;
    axis_x <= ax; axis_y <= ay; axis_z <= az;
    turn_angle <= ang;
    pending_rotations.push_back(rotate_point(px, py, pz, ax, ay, az, ang));
    sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk) start <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      rotated_t e;
      if (pending_rotations.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = pending_rotations.pop_front();
        checked++;
        if (clipped) clipped_seen++;
        if (rotated_x !== e.x || rotated_y !== e.y || rotated_z !== e.z ||
            clipped !== e.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d clip %0b, got %0d %0d %0d clip %0b",
                     e.x, e.y, e.z, e.clip, rotated_x, rotated_y, rotated_z, clipped);
        end
      end
    end
  end

  task automatic test_extremes();
    logic [15:0] angs[8] = '{16'h0000, 16'h2000, 16'h3FFF, 16'h4000, 16'h8000,
                             16'hC000, 16'hE001, 16'hFFFF};
    foreach (angs[i])
      send_item(16'sd256, -16'sd512, 16'sd1024, 16'sd9459, 16'sd9459, 16'sd9459, angs[i], 0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd16384, 16'sd0, 16'sd0, 16'h1000, 0);
    send_item(-16'sh8000, -16'sh8000, -16'sh8000, 16'sd0, 16'sd16384, 16'sd0, 16'h2000, 1);
    send_item(16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, -16'sd16384, 16'h6000, 0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd16384, 16'sd16384, 16'sd16384,
              16'h1555, 0);
    send_item(16'sd1000, 16'sd2000, 16'sd3000, 16'sd8000, 16'sd0, 16'sd0, 16'h3000, 2);
    send_item(16'sd1000, -16'sd2000, 16'sd300, -16'sh8000, 16'sh7FFF, -16'sh8000,
              16'hA000, 0);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h1234, 0);
    send_item(16'sd5000, 16'sd5000, 16'sd5000, 16'sd0, 16'sd0, 16'sd0, 16'h4321, 0);
    wait_drained();
  endtask

  task automatic test_random_unit_axes(int count);
    int k;
    logic signed [15:0] a[3];
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(2);
      foreach (a[i]) a[i] = 16'($signed($urandom_range(16384, 0)) - 8192);
      a[k] = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
      if ($urandom_range(3) == 0) foreach (a[i]) a[i] = 16'(5000 + $urandom_range(5000));
      send_item(16'($urandom_range(16383)) - 16'sd8192, 16'($urandom), 16'($urandom),
                a[0], a[1], a[2], 16'($urandom),
                (n > count / 2 && n < count / 2 + 200) ? 0 : gap_len());
      if (n == count / 3) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_random_raw(int count);
    for (int n = 0; n < count; n++)
      send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), gap_len());
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_random_unit_axes(1500);
    test_random_raw(450);
    $display("sent %0d items, checked %0d results, %0d clipped, %0d mismatches",
             sent, checked, clipped_seen, mismatches);
    if (mismatches == 0 && pending_rotations.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
